/* rtl/core/ellipse_arc_vertex_generator_assert.svh */
`ifndef ELLIPSE_ARC_VERTEX_GENERATOR_ASSERT_SVH
`define ELLIPSE_ARC_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define EVG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("evg assertion failed");

// next-cycle implication
`define EVG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("evg assertion failed");

`endif

/* rtl/core/evg_pkg.sv */
package evg_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 1000;
  localparam int unsigned CORDIC_STEPS = 30;

  localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;
  localparam logic [31:0] SEG_DIVISOR = 32'd1686630400;
  // ceil(2^49 / 411775), exact for the quotients below the segment cap
  localparam logic [31:0] SEG_RECIP = 32'd1367129995;
  localparam int unsigned SEG_RECIP_SHIFT = 49;
  localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;

  localparam logic [2:0] REG_MAJOR_RADIUS = 3'd0;
  localparam logic [2:0] REG_MINOR_RADIUS = 3'd1;
  localparam logic [2:0] REG_START_ANGLE = 3'd2;
  localparam logic [2:0] REG_END_ANGLE = 3'd3;
  localparam logic [2:0] REG_CENTER_X = 3'd4;
  localparam logic [2:0] REG_CENTER_Y = 3'd5;
  localparam logic [2:0] REG_AXIS_COS = 3'd6;
  localparam logic [2:0] REG_AXIS_SIN = 3'd7;

  localparam logic ACT_START = 1'b0;

  typedef struct packed {
    logic        action;
    logic [31:0] pixel_scale;
  } evg_in_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
    logic               no_arc_error;
  } evg_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_PIX, S_SWEEP, S_SEGDIV, S_DOUBLE, S_THDIV, S_THCOS,
    S_TANDIV, S_RATDIV, S_STCOS, S_LX, S_LY, S_YR, S_XC, S_YS, S_XS, S_YC,
    S_OUT, S_T1, S_T2, S_R1, S_R2
  } evg_state_e;

  typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_DONE} evg_mul_phase_e;

  typedef enum logic [1:0] {C_IDLE, C_RED, C_ITER, C_FIN} evg_cordic_state_e;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< 47) - 64'sd1;
    lo = -(64'sd1 <<< 47);
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: return 30'd843314857;
      5'd1: return 30'd497837829;
      5'd2: return 30'd263043837;
      5'd3: return 30'd133525159;
      5'd4: return 30'd67021687;
      5'd5: return 30'd33543516;
      5'd6: return 30'd16775851;
      5'd7: return 30'd8388437;
      5'd8: return 30'd4194283;
      5'd9: return 30'd2097149;
      default: return 30'd1 << (5'd30 - i);
    endcase
  endfunction

endpackage

/* rtl/core/evg_mul.sv */
module evg_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [47:0]  a_i,
  input  logic signed [32:0]  b_i,
  output logic                done_o,
  output logic signed [80:0]  prod_o
);
  import evg_pkg::*;

  evg_mul_phase_e     phase_q;
  logic signed [47:0] a_q;
  logic signed [32:0] b_q;
  logic signed [80:0] acc_q;
  logic signed [32:0] m_a;
  logic signed [65:0] m_p;

  assign m_a = (phase_q == MP_LO) ? $signed({17'b0, a_q[15:0]})
                                  : $signed({a_q[47], a_q[47:16]});
  assign m_p = m_a * b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
    end else begin
      case (phase_q)
        MP_IDLE: if (start_i) phase_q <= MP_LO;
        MP_LO:   phase_q <= MP_HI;
        MP_HI:   phase_q <= MP_DONE;
        MP_DONE: phase_q <= MP_IDLE;
        default: phase_q <= MP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == MP_IDLE && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (phase_q == MP_LO) acc_q <= 81'(m_p);
    if (phase_q == MP_HI) acc_q <= acc_q + $signed({m_p[64:0], 16'b0});
  end

  assign done_o = (phase_q == MP_DONE);
  assign prod_o = acc_q;

endmodule

/* rtl/core/evg_div.sv */
module evg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  import evg_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [31:0] dvs_q;
  logic [32:0] rem_q;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q[31:0], dvd_q[63]};
  assign ge = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_q <= {dvd_q[62:0], ge};
    end else if (start_i) begin
      rem_q <= '0;
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

/* rtl/core/evg_cordic.sv */
module evg_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [35:0] ang_i,
  output logic               done_o,
  output logic signed [35:0] cos_o,
  output logic signed [35:0] sin_o
);
  import evg_pkg::*;

  evg_cordic_state_e  st_q;
  logic               done_q;
  logic               flip_q;
  logic [4:0]         i_q;
  logic signed [35:0] x_q, y_q, z_q, c_q, s_q;
  logic signed [35:0] sx, sy, at;

  assign sx = x_q >>> i_q;
  assign sy = y_q >>> i_q;
  assign at = $signed({6'b0, atan_q30(i_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        C_IDLE: if (start_i) st_q <= C_RED;
        C_RED: begin
          if (!(z_q > PI_Q30) && !(z_q <= -PI_Q30)) st_q <= C_ITER;
        end
        C_ITER: if (i_q == 5'(CORDIC_STEPS - 1)) st_q <= C_FIN;
        C_FIN: begin
          st_q   <= C_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      C_IDLE: begin
        if (start_i) begin
          z_q    <= ang_i;
          x_q    <= CORDIC_GAIN;
          y_q    <= '0;
          i_q    <= '0;
          flip_q <= 1'b0;
        end
      end
      C_RED: begin
        if (z_q > PI_Q30) begin
          z_q <= z_q - TWO_PI_Q30;
        end else if (z_q <= -PI_Q30) begin
          z_q <= z_q + TWO_PI_Q30;
        end else if (z_q > HALF_PI_Q30) begin
          z_q    <= z_q - PI_Q30;
          flip_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q30) begin
          z_q    <= z_q + PI_Q30;
          flip_q <= 1'b1;
        end
      end
      C_ITER: begin
        if (z_q >= 0) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + at;
        end
        i_q <= i_q + 5'd1;
      end
      C_FIN: begin
        c_q <= flip_q ? -x_q : x_q;
        s_q <= flip_q ? -y_q : y_q;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = c_q;
  assign sin_o  = s_q;

endmodule

/* rtl/core/ellipse_arc_vertex_generator.sv */
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (action, pixel_scale)
// out     | output    | out_valid_o / out_stall_i | out_data_o (vertex, flags)
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A start beat runs up to three 64-step passes of the shared divider,
// two CORDIC passes and up to fourteen products.
// A next beat runs nine products; the last vertex runs five.
// A next beat with no arc runs no products and goes straight to the result stage.
// Reset clears all control state and loads the register defaults; no clearing pass.
// A new beat is taken while a result waits; the result stage holds until out_stall_i drops.
module ellipse_arc_vertex_generator #(
  parameter int unsigned MAX_SEGMENTS = evg_pkg::MAX_SEGMENTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  evg_pkg::evg_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output evg_pkg::evg_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i
);
  import evg_pkg::*;

  localparam int unsigned SegW = $clog2(MAX_SEGMENTS + 1) + 3;
  localparam logic [63:0] SegCap = 64'(SEG_DIVISOR) * 64'(MAX_SEGMENTS);

  logic [31:0]        major_q, minor_q;
  logic signed [19:0] start_ang_q, end_ang_q;
  logic signed [31:0] cx_q, cy_q, acos_q, asin_q;

  evg_state_e         state_q, state_d;
  logic               launch_q;
  logic [31:0]        pix_q, pix_d;
  logic signed [20:0] d_q, d_d;
  logic [SegW-1:0]    segs_q, segs_d;
  logic [31:0]        cadj_q, cadj_d;
  logic [31:0]        tg_q, tg_d, rg_q, rg_d, ratio_q, ratio_d;
  logic signed [47:0] lx_q, lx_d, ly_q, ly_d, x1_q, x1_d, y1_q, y1_d, yr_q, yr_d;
  logic signed [63:0] acc_q, acc_d;
  evg_out_t           res_q, res_d, out_q, out_d;
  logic               adv_q, adv_d, active_q, active_d, out_valid_q, out_valid_d;
  logic [10:0]        vl_q, vl_d;

  logic               in_acc, out_acc;
  logic               mul_go, mul_done, div_go, div_done, cor_go, cor_done;
  logic signed [47:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [80:0] mul_prod, mq_sh, lp_sh;
  logic signed [63:0] mq, px;
  logic [63:0]        div_dvd, div_quo;
  logic [31:0]        div_dvs;
  logic signed [35:0] cor_ang, cor_c, cor_s;
  logic signed [20:0] sweep;
  logic signed [36:0] rg_full;
  logic [39:0]        seg_lim;
  logic [31:0]        segs_ext;

  evg_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  evg_div u_div (
    .clk_i, .rst_ni, .start_i(div_go), .dvd_i(div_dvd), .dvs_i(div_dvs),
    .done_o(div_done), .quo_o(div_quo)
  );

  evg_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_go), .ang_i(cor_ang),
    .done_o(cor_done), .cos_o(cor_c), .sin_o(cor_s)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mq_sh    = mul_prod >>> 30;
  assign mq       = $signed(mq_sh[63:0]);
  assign lp_sh    = mul_prod >>> 16;
  assign px       = acc_q - mq;
  assign sweep    = {end_ang_q[19], end_ang_q} - {start_ang_q[19], start_ang_q};
  assign rg_full  = ONE_Q30 - $signed({5'b0, cadj_q});
  assign seg_lim  = 40'(segs_q) << 16;
  assign segs_ext = 32'(segs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q     <= 32'd65536;
      minor_q     <= 32'd65536;
      start_ang_q <= '0;
      end_ang_q   <= 20'sd411775;
      cx_q        <= '0;
      cy_q        <= '0;
      acos_q      <= 32'sd1073741824;
      asin_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAJOR_RADIUS: major_q     <= cfg_wdata_i;
        REG_MINOR_RADIUS: minor_q     <= cfg_wdata_i;
        REG_START_ANGLE:  start_ang_q <= $signed(cfg_wdata_i[19:0]);
        REG_END_ANGLE:    end_ang_q   <= $signed(cfg_wdata_i[19:0]);
        REG_CENTER_X:     cx_q        <= $signed(cfg_wdata_i);
        REG_CENTER_Y:     cy_q        <= $signed(cfg_wdata_i);
        REG_AXIS_COS:     acos_q      <= $signed(cfg_wdata_i);
        REG_AXIS_SIN:     asin_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      lx_q        <= '0;
      ly_q        <= '0;
      tg_q        <= '0;
      rg_q        <= '0;
      ratio_q     <= '0;
      vl_q        <= '0;
      active_q    <= 1'b0;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= (state_d != state_q);
      lx_q        <= lx_d;
      ly_q        <= ly_d;
      tg_q        <= tg_d;
      rg_q        <= rg_d;
      ratio_q     <= ratio_d;
      vl_q        <= vl_d;
      active_q    <= active_d;
      adv_q       <= adv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    d_q    <= d_d;
    segs_q <= segs_d;
    cadj_q <= cadj_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    yr_q   <= yr_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d = state_q;
    pix_d = pix_q; d_d = d_q; segs_d = segs_q; cadj_d = cadj_q;
    tg_d = tg_q; rg_d = rg_q; ratio_d = ratio_q;
    lx_d = lx_q; ly_d = ly_q; x1_d = x1_q; y1_d = y1_q; yr_d = yr_q;
    acc_d = acc_q; res_d = res_q; out_d = out_q;
    adv_d = adv_q; active_d = active_q; vl_d = vl_q;
    out_valid_d = out_valid_q && !out_acc;
    mul_go = 1'b0; div_go = 1'b0; cor_go = 1'b0;
    mul_a = '0; mul_b = '0; div_dvd = '0; div_dvs = '0; cor_ang = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d.last_vertex  = 1'b0;
          res_d.no_arc_error = 1'b0;
          if (in_data_i.action == ACT_START) begin
            pix_d   = in_data_i.pixel_scale;
            d_d     = (sweep == 21'sd0) ? TWO_PI_Q16 : sweep;
            state_d = S_WRAP;
          end else if (!active_q) begin
            res_d.vertex_x     = '0;
            res_d.vertex_y     = '0;
            res_d.no_arc_error = 1'b1;
            adv_d   = 1'b0;
            state_d = S_OUT;
          end else begin
            vl_d = vl_q - 11'd1;
            if (vl_d == 11'd0) begin
              res_d.last_vertex = 1'b1;
              active_d = 1'b0;
              adv_d    = 1'b0;
            end else begin
              adv_d = 1'b1;
            end
            state_d = S_YR;
          end
        end
      end
      S_WRAP: begin
        if (d_q < 0) d_d = d_q + TWO_PI_Q16;
        else state_d = S_PIX;
      end
      S_PIX: begin
        mul_go = launch_q;
        mul_a  = $signed({16'b0, pix_q});
        mul_b  = $signed({1'b0, major_q});
        if (mul_done) state_d = S_SWEEP;
      end
      S_SWEEP: begin
        mul_go = launch_q;
        mul_a  = $signed({4'b0, mul_prod[63:20]});
        mul_b  = 33'(d_q);
        if (mul_done) state_d = S_SEGDIV;
      end
      S_SEGDIV: begin
        mul_a = $signed({18'b0, mul_prod[41:12]});
        mul_b = $signed({1'b0, SEG_RECIP});
        if (launch_q) begin
          if (mul_prod[63:0] >= SegCap) begin
            segs_d  = SegW'(MAX_SEGMENTS);
            state_d = S_DOUBLE;
          end else begin
            mul_go = 1'b1;
          end
        end else if (mul_done) begin
          segs_d  = mul_prod[SEG_RECIP_SHIFT +: SegW] + SegW'(1);
          state_d = S_DOUBLE;
        end
      end
      S_DOUBLE: begin
        if (40'($unsigned(d_q)) > seg_lim) segs_d = segs_q << 1;
        else state_d = S_THDIV;
      end
      S_THDIV: begin
        div_go  = launch_q;
        div_dvd = {29'b0, d_q, 14'b0};
        div_dvs = segs_ext;
        if (div_done) state_d = S_THCOS;
      end
      S_THCOS: begin
        cor_go  = launch_q;
        cor_ang = $signed(div_quo[35:0]);
        if (cor_done) begin
          cadj_d = (cor_c <= 0) ? 32'd1 : cor_c[31:0];
          if (cor_s < 0) begin
            tg_d = '0;
            state_d = S_RATDIV;
          end else begin
            state_d = S_TANDIV;
          end
        end
      end
      S_TANDIV: begin
        div_go  = launch_q;
        div_dvd = {cor_s[33:0], 30'b0};
        div_dvs = cadj_q;
        if (div_done) begin
          tg_d = (div_quo > 64'(GAIN_MAX)) ? GAIN_MAX : div_quo[31:0];
          state_d = S_RATDIV;
        end
      end
      S_RATDIV: begin
        rg_d = (rg_full < 0) ? 32'd0 : rg_full[31:0];
        if (major_q == 32'd0) begin
          ratio_d = '0;
          state_d = S_STCOS;
        end else begin
          div_go  = launch_q;
          div_dvd = {2'b0, minor_q, 30'b0};
          div_dvs = major_q;
          if (div_done) begin
            ratio_d = (div_quo > 64'(GAIN_MAX)) ? GAIN_MAX : div_quo[31:0];
            state_d = S_STCOS;
          end
        end
      end
      S_STCOS: begin
        cor_go  = launch_q;
        cor_ang = {{2{start_ang_q[19]}}, start_ang_q, 14'b0};
        if (cor_done) state_d = S_LX;
      end
      S_LX: begin
        mul_go = launch_q;
        mul_a  = $signed({16'b0, major_q});
        mul_b  = 33'(cor_c);
        if (mul_done) begin
          lx_d = sat48($signed(lp_sh[63:0]));
          state_d = S_LY;
        end
      end
      S_LY: begin
        mul_go = launch_q;
        mul_a  = $signed({16'b0, major_q});
        mul_b  = 33'(cor_s);
        if (mul_done) begin
          ly_d     = sat48($signed(lp_sh[63:0]));
          vl_d     = segs_ext[10:0];
          active_d = 1'b1;
          adv_d    = 1'b1;
          state_d  = S_YR;
        end
      end
      S_YR: begin
        mul_go = launch_q;
        mul_a  = ly_q;
        mul_b  = $signed({1'b0, ratio_q});
        if (mul_done) begin
          yr_d = sat48(mq);
          state_d = S_XC;
        end
      end
      S_XC: begin
        mul_go = launch_q;
        mul_a  = lx_q;
        mul_b  = 33'(acos_q);
        if (mul_done) begin
          acc_d = mq;
          state_d = S_YS;
        end
      end
      S_YS: begin
        mul_go = launch_q;
        mul_a  = yr_q;
        mul_b  = 33'(asin_q);
        if (mul_done) begin
          res_d.vertex_x = sat32((px >>> 14) + 64'(cx_q));
          state_d = S_XS;
        end
      end
      S_XS: begin
        mul_go = launch_q;
        mul_a  = lx_q;
        mul_b  = 33'(asin_q);
        if (mul_done) begin
          acc_d = mq;
          state_d = S_YC;
        end
      end
      S_YC: begin
        mul_go = launch_q;
        mul_a  = yr_q;
        mul_b  = 33'(acos_q);
        if (mul_done) begin
          res_d.vertex_y = sat32(((acc_q + mq) >>> 14) + 64'(cy_q));
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_acc) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = adv_q ? S_T1 : S_IDLE;
        end
      end
      S_T1: begin
        mul_go = launch_q;
        mul_a  = ly_q;
        mul_b  = $signed({1'b0, tg_q});
        if (mul_done) begin
          x1_d = sat48(64'(lx_q) - mq);
          state_d = S_T2;
        end
      end
      S_T2: begin
        mul_go = launch_q;
        mul_a  = lx_q;
        mul_b  = $signed({1'b0, tg_q});
        if (mul_done) begin
          y1_d = sat48(64'(ly_q) + mq);
          state_d = S_R1;
        end
      end
      S_R1: begin
        mul_go = launch_q;
        mul_a  = x1_q;
        mul_b  = $signed({1'b0, rg_q});
        if (mul_done) begin
          lx_d = sat48(64'(x1_q) - mq);
          state_d = S_R2;
        end
      end
      S_R2: begin
        mul_go = launch_q;
        mul_a  = y1_q;
        mul_b  = $signed({1'b0, rg_q});
        if (mul_done) begin
          ly_d = sat48(64'(y1_q) - mq);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`include "ellipse_arc_vertex_generator_assert.svh"

  `EVG_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_acc, state_q != S_IDLE)
  `EVG_ASSERT_IMP(a_active_has_left, clk_i, rst_ni, (state_q == S_IDLE) && active_q, vl_q != 11'd0)
  `EVG_ASSERT_IMP(a_error_beat_clean, clk_i, rst_ni, out_valid_o && out_data_o.no_arc_error, (out_data_o.vertex_x == 32'sd0) && (out_data_o.vertex_y == 32'sd0) && !out_data_o.last_vertex)

endmodule

/* bench/evg_vertex_checker.sv */
`timescale 1ns / 100ps
module evg_vertex_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  evg_pkg::evg_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  evg_pkg::evg_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                vertex_count_o
);
  import evg_pkg::*;

  localparam longint TWO_PI = 411775;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint TWO_PI_Q = 64'sd6746518852;
  localparam longint ONE_Q = 64'sd1073741824;
  localparam longint GAIN_Q = 64'sd652032874;
  localparam longint SEG_DIV = 64'sd1686630400;
  localparam longint ATAN_TAB [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  logic [31:0] major_r, minor_r, center_x, center_y, axis_c, axis_s;
  logic [19:0] start_ang, end_ang;
  longint pos_x, pos_y, tan_gain, rad_gain, ratio;
  logic [10:0] verts_left;
  logic arc_on;
  evg_out_t vertex_q[$];

  assign pending_o = vertex_q.size();

  function automatic longint clip48(longint v);
    longint hi;
    hi = (64'sd1 <<< 47) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint hi, lo;
    hi = a >>> 16;
    lo = a - hi * 65536;
    return (hi * b + ((lo * b) >>> 16)) >>> 14;
  endfunction

  function automatic void rotate(longint ang, output longint c, output longint s);
    longint x, y, z, t;
    bit flip;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    while (ang > PI_Q) ang -= TWO_PI_Q;
    while (ang <= -PI_Q) ang += TWO_PI_Q;
    if (ang > HALF_PI_Q) begin
      ang -= PI_Q;
      flip = 1;
    end else if (ang < -HALF_PI_Q) begin
      ang += PI_Q;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] place(longint q30, logic [31:0] ctr);
    longint v;
    v = (q30 >>> 14) + longint'(signed'(ctr));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic evg_out_t vertex_at(bit last);
    evg_out_t r;
    longint c, s, yr, px, py;
    c = longint'(signed'(axis_c));
    s = longint'(signed'(axis_s));
    yr = clip48(mul_q30(pos_y, ratio));
    px = mul_q30(pos_x, c) - mul_q30(yr, s);
    py = mul_q30(pos_x, s) + mul_q30(yr, c);
    r.vertex_x = place(px, center_x);
    r.vertex_y = place(py, center_y);
    r.last_vertex = last;
    r.no_arc_error = 1'b0;
    return r;
  endfunction

  function automatic void step_point();
    longint x1, y1;
    x1 = clip48(pos_x - mul_q30(pos_y, tan_gain));
    y1 = clip48(pos_y + mul_q30(pos_x, tan_gain));
    pos_x = clip48(x1 - mul_q30(x1, rad_gain));
    pos_y = clip48(y1 - mul_q30(y1, rad_gain));
  endfunction

  function automatic evg_out_t next_vertex(evg_in_t beat);
    evg_out_t r;
    longint unsigned pix, q, rt;
    longint st, d, segs, theta, c, s, tn;
    if (beat.action == ACT_START) begin
      pix = beat.pixel_scale;
      st = longint'(signed'(start_ang));
      d = longint'(signed'(end_ang)) - st;
      if (d == 0) d = TWO_PI;
      while (d < 0) d += TWO_PI;
      q = ((pix * longint'(major_r)) >> 20) * longint'(d) / SEG_DIV;
      segs = (q >= MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : longint'(q) + 1;
      while (d > segs * 65536) segs *= 2;
      theta = (d * 16384) / segs;
      rotate(theta, c, s);
      if (c <= 0) c = 1;
      tn = (s * ONE_Q) / c;
      if (tn < 0) tn = 0;
      if (tn > 64'sh7FFF_FFFF) tn = 64'sh7FFF_FFFF;
      tan_gain = tn;
      rad_gain = ONE_Q - c;
      if (rad_gain < 0) rad_gain = 0;
      if (major_r == 0) rt = 0;
      else begin
        rt = (longint'(minor_r) << 30) / longint'(major_r);
        if (rt > 64'h7FFF_FFFF) rt = 64'h7FFF_FFFF;
      end
      ratio = longint'(rt);
      rotate(st * 16384, c, s);
      pos_x = clip48((longint'(major_r) * c) >>> 16);
      pos_y = clip48((longint'(major_r) * s) >>> 16);
      r = vertex_at(1'b0);
      step_point();
      verts_left = segs[10:0];
      arc_on = 1'b1;
      return r;
    end
    if (!arc_on) begin
      r = '0;
      r.no_arc_error = 1'b1;
      return r;
    end
    verts_left = verts_left - 11'd1;
    if (verts_left == 0) begin
      r = vertex_at(1'b1);
      arc_on = 1'b0;
    end else begin
      r = vertex_at(1'b0);
      step_point();
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evg_out_t want;
    if (!rst_ni) begin
      major_r = 32'd65536;
      minor_r = 32'd65536;
      start_ang = '0;
      end_ang = 20'd411775;
      center_x = '0;
      center_y = '0;
      axis_c = 32'd1073741824;
      axis_s = '0;
      pos_x = 0;
      pos_y = 0;
      tan_gain = 0;
      rad_gain = 0;
      ratio = 0;
      verts_left = '0;
      arc_on = 1'b0;
      vertex_q.delete();
      fail_count_o = 0;
      vertex_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        vertex_count_o++;
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = vertex_q.pop_front();
          if (out_data_i.vertex_x !== want.vertex_x)
            report_mismatch("vertex_x", out_data_i.vertex_x, want.vertex_x);
          if (out_data_i.vertex_y !== want.vertex_y)
            report_mismatch("vertex_y", out_data_i.vertex_y, want.vertex_y);
          if (out_data_i.last_vertex !== want.last_vertex)
            report_mismatch("last_vertex", out_data_i.last_vertex, want.last_vertex);
          if (out_data_i.no_arc_error !== want.no_arc_error)
            report_mismatch("no_arc_error", out_data_i.no_arc_error, want.no_arc_error);
        end
      end
      if (in_valid_i && !in_stall_i)
        vertex_q.insert(vertex_q.size(), next_vertex(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAJOR_RADIUS: major_r = cfg_wdata_i;
          REG_MINOR_RADIUS: minor_r = cfg_wdata_i;
          REG_START_ANGLE:  start_ang = cfg_wdata_i[19:0];
          REG_END_ANGLE:    end_ang = cfg_wdata_i[19:0];
          REG_CENTER_X:     center_x = cfg_wdata_i;
          REG_CENTER_Y:     center_y = cfg_wdata_i;
          REG_AXIS_COS:     axis_c = cfg_wdata_i;
          REG_AXIS_SIN:     axis_s = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import evg_pkg::*;

  localparam logic ACT_NEXT = ~ACT_START;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  evg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  evg_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = REG_MAJOR_RADIUS;
  logic [31:0] cfg_wdata = '0;
  int fail_count, pending, vertex_count;
  int beats, starts, settings;
  bit calm = 1'b0;

  always #2 clk_i = ~clk_i;

  ellipse_arc_vertex_generator i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  evg_vertex_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .vertex_count_o(vertex_count)
  );

  always begin
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      out_stall = 1'b0;
    end
  end

  task automatic send_beat(logic act, logic [31:0] pix);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.action = act;
    in_data.pixel_scale = pix;
    do @(posedge clk_i); while (in_stall);
    beats++;
    if (act == ACT_START) starts++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0 || in_stall) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h4000, 32'h40000);
    endcase
  endfunction

  function automatic logic [31:0] pick_axis();
    case ($urandom_range(0, 4))
      0: return 32'd1073741824;
      1: return -32'sd1073741824;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_center();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic new_setting();
    drain();
    settings++;
    write_reg(REG_MAJOR_RADIUS, pick_radius());
    write_reg(REG_MINOR_RADIUS, pick_radius());
    write_reg(REG_START_ANGLE, $urandom);
    write_reg(REG_END_ANGLE, $urandom_range(0, 3) == 0 ? 32'd411775 : $urandom);
    write_reg(REG_CENTER_X, pick_center());
    write_reg(REG_CENTER_Y, pick_center());
    write_reg(REG_AXIS_COS, pick_axis());
    write_reg(REG_AXIS_SIN, pick_axis());
  endtask

  task automatic walk_arc(logic [31:0] pix, int steps);
    send_beat(ACT_START, pix);
    repeat (steps) send_beat(ACT_NEXT, $urandom);
  endtask

  initial begin
    logic [31:0] pix;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_beat(ACT_NEXT, 32'hFFFF_FFFF);
    walk_arc(32'd0, 9);
    walk_arc(32'hFFFF_FFFF, 3);
    drain();
    write_reg(REG_START_ANGLE, 32'd205887);
    write_reg(REG_END_ANGLE, -32'sd205888);
    walk_arc(32'h0001_0000, 2);
    drain();
    write_reg(REG_END_ANGLE, 32'd205887);
    write_reg(REG_MAJOR_RADIUS, 32'd0);
    write_reg(REG_MINOR_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    write_reg(REG_AXIS_COS, -32'sd1073741824);
    write_reg(REG_AXIS_SIN, 32'd1073741824);
    walk_arc(32'h0002_0000, 2);
    drain();
    write_reg(REG_MAJOR_RADIUS, 32'd1);
    write_reg(REG_START_ANGLE, 32'h7FFFF);
    write_reg(REG_END_ANGLE, 32'h80000);
    walk_arc(32'h0004_0000, 3);
    while (beats < 1500) begin
      calm = (beats > 1300) || ($urandom_range(0, 4) == 0);
      new_setting();
      repeat ($urandom_range(3, 12)) begin
        pix = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h0018_0000);
        if (beats < 1500)
          walk_arc(pix, $urandom_range(0, 3) == 0 ? $urandom_range(0, 60)
                                                  : $urandom_range(0, 14));
      end
    end
    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d beats, %0d arc starts, %0d vertices checked,", beats, starts,
             vertex_count);
    $display("over %0d register settings.", settings + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/evg_pkg.sv
rtl/core/evg_mul.sv
rtl/core/evg_div.sv
rtl/core/evg_cordic.sv
rtl/core/ellipse_arc_vertex_generator.sv
bench/evg_vertex_checker.sv
bench/tb_top.sv
